/* rtl/md4_pkg.sv */
package md4_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] K2  = 32'h5A827999;
    localparam logic [31:0] K3  = 32'h6ED9EBA1;

    localparam int unsigned ROUNDS = 48;
    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);

    typedef logic [3:0][31:0] md4_chain_t;

    typedef struct packed {
        logic        init;
        logic        start;
        logic        wr_en;
        logic [3:0]  wr_addr;
        logic [31:0] wr_data;
    } md4_ctrl_t;

    function automatic logic [3:0] word_order(input logic [5:0] idx);
        logic [3:0] j;
        logic [3:0] w;
        j = idx[3:0];
        if (idx < 6'd16)
        begin
            w = j;
        end
        else if (idx < 6'd32)
        begin
            w = {j[1:0], j[3:2]};
        end
        else
        begin
            w = {j[0], j[1], j[2], j[3]};
        end
        return w;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] idx);
        logic [4:0] r;
        if (idx < 6'd16)
        begin
            unique case (idx[1:0])
                2'd0: r = 5'd3;
                2'd1: r = 5'd7;
                2'd2: r = 5'd11;
                2'd3: r = 5'd19;
            endcase
        end
        else if (idx < 6'd32)
        begin
            unique case (idx[1:0])
                2'd0: r = 5'd3;
                2'd1: r = 5'd5;
                2'd2: r = 5'd9;
                2'd3: r = 5'd13;
            endcase
        end
        else
        begin
            unique case (idx[1:0])
                2'd0: r = 5'd3;
                2'd1: r = 5'd9;
                2'd2: r = 5'd11;
                2'd3: r = 5'd15;
            endcase
        end
        return r;
    endfunction

    function automatic logic [31:0] byte_swap(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

/* rtl/md4_core.sv */
module md4_core (
    input  logic               clk,
    input  logic               rst_n,
    input  md4_pkg::md4_ctrl_t ctrl,
    output logic               done,
    output md4_pkg::md4_chain_t chain
);
    import md4_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_FIN  = 2'd2;

    logic [31:0] block_mem [16];
    logic [31:0] rdata_reg;
    logic [3:0]  rd_addr;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    md4_chain_t  chain_reg, chain_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;

    logic [31:0] fv;
    logic [31:0] kv;
    logic [31:0] sum;
    logic [63:0] rot_wide;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            block_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        rdata_reg <= block_mem[rd_addr];
    end

    always_comb
    begin
        if (state_reg == C_RUN)
        begin
            rd_addr = word_order(round_reg + 6'd1);
        end
        else
        begin
            rd_addr = word_order(6'd0);
        end
    end

    always_comb
    begin
        if (round_reg < 6'd16)
        begin
            fv = (b_reg & c_reg) | (~b_reg & d_reg);
            kv = '0;
        end
        else if (round_reg < 6'd32)
        begin
            fv = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            kv = K2;
        end
        else
        begin
            fv = b_reg ^ c_reg ^ d_reg;
            kv = K3;
        end
        sum = a_reg + fv + rdata_reg + kv;
        rot_wide = {sum, sum} << rot_amount(round_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        done = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    a_next = chain_reg[0];
                    b_next = chain_reg[1];
                    c_next = chain_reg[2];
                    d_next = chain_reg[3];
                    round_next = '0;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                a_next = d_reg;
                d_next = c_reg;
                c_next = b_reg;
                b_next = rot_wide[63:32];
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = C_FIN;
                end
            end
            C_FIN:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                done = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
        if (ctrl.init)
        begin
            chain_next = {IV3, IV2, IV1, IV0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            chain_reg <= {IV3, IV2, IV1, IV0};
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign chain = chain_reg;

endmodule

/* rtl/md4_hash_engine.sv */
// An item without end of message is taken while the engine is idle; the byte that
// fills a block starts a compression (48 rounds, one word read ahead from the
// block memory, one chaining add), during which no item is taken.
// An end-of-message item pads through up to 16 memory writes per block, runs one
// or two compressions and loads its digest once the output register is free.
// Reset (asynchronous, active low) loads the MD4 initial values and clears the count.
module md4_hash_engine (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // byte_present
    input  logic         s_tlast,   // end_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // digest_high, digest_low
);
    import md4_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CSTART = 3'd1;
    localparam logic [2:0] S_CWAIT  = 3'd2;
    localparam logic [2:0] S_PAD    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]   state_reg, state_next;
    logic [5:0]   pos_reg, pos_next;
    logic [31:0]  acc_reg, acc_next;
    logic [63:0]  bitlen_reg, bitlen_next;
    logic         end_pend_reg, end_pend_next;
    logic         marker_done_reg, marker_done_next;
    logic         len_done_reg, len_done_next;
    logic [3:0]   pad_word_reg, pad_word_next;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] out_data_reg, out_data_next;

    md4_ctrl_t    ctrl;
    logic         core_done;
    md4_chain_t   chain;

    logic         accept;
    logic [31:0]  byte_word;
    logic [31:0]  acc_new;
    logic [31:0]  marker;
    logic [31:0]  marker_word;
    logic         len_block;

    md4_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .done  (core_done),
        .chain (chain)
    );

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        byte_word = 32'(s_tdata) << {pos_reg[1:0], 3'b000};
        acc_new = (pos_reg[1:0] == 2'd0) ? byte_word : (acc_reg | byte_word);
        marker = 32'h0000_0080 << {pos_reg[1:0], 3'b000};
        marker_word = (pos_reg[1:0] == 2'd0) ? marker : (acc_reg | marker);
        len_block = marker_done_reg || (pos_reg < 6'd56);
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        acc_next = acc_reg;
        bitlen_next = bitlen_reg;
        end_pend_next = end_pend_reg;
        marker_done_next = marker_done_reg;
        len_done_next = len_done_reg;
        pad_word_next = pad_word_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        ctrl = '0;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        acc_next = acc_new;
                        pos_next = pos_reg + 6'd1;
                        bitlen_next = bitlen_reg + 64'd8;
                        ctrl.wr_en = (pos_reg[1:0] == 2'd3);
                        ctrl.wr_addr = pos_reg[5:2];
                        ctrl.wr_data = acc_new;
                    end
                    if (s_tuser && pos_reg == 6'd63)
                    begin
                        end_pend_next = s_tlast;
                        state_next = S_CSTART;
                    end
                    else if (s_tlast)
                    begin
                        end_pend_next = 1'b1;
                        pad_word_next = pos_next[5:2];
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ctrl.wr_en = 1'b1;
                ctrl.wr_addr = pad_word_reg;
                if (!marker_done_reg && pad_word_reg == pos_reg[5:2])
                begin
                    ctrl.wr_data = marker_word;
                end
                else if (len_block && pad_word_reg == 4'd14)
                begin
                    ctrl.wr_data = bitlen_reg[31:0];
                end
                else if (len_block && pad_word_reg == 4'd15)
                begin
                    ctrl.wr_data = bitlen_reg[63:32];
                end
                else
                begin
                    ctrl.wr_data = '0;
                end
                if (pad_word_reg == 4'd15)
                begin
                    marker_done_next = 1'b1;
                    len_done_next = len_block;
                    state_next = S_CSTART;
                end
                else
                begin
                    pad_word_next = pad_word_reg + 4'd1;
                end
            end
            S_CSTART:
            begin
                ctrl.start = 1'b1;
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (core_done)
                begin
                    if (!end_pend_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!len_done_reg)
                    begin
                        pad_word_next = marker_done_reg ? 4'd0 : pos_reg[5:2];
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {byte_swap(chain[2]), byte_swap(chain[3]),
                                     byte_swap(chain[0]), byte_swap(chain[1])};
                    ctrl.init = 1'b1;
                    pos_next = '0;
                    bitlen_next = '0;
                    end_pend_next = 1'b0;
                    marker_done_next = 1'b0;
                    len_done_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg <= '0;
            bitlen_reg <= '0;
            end_pend_reg <= 1'b0;
            marker_done_reg <= 1'b0;
            len_done_reg <= 1'b0;
            pad_word_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            bitlen_reg <= bitlen_next;
            end_pend_reg <= end_pend_next;
            marker_done_reg <= marker_done_next;
            len_done_reg <= len_done_next;
            pad_word_reg <= pad_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> state_reg == S_CWAIT)
        else $error("compression finished outside the wait state");

    a_pad_then_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD && pad_word_reg == 4'd15) |=> state_reg == S_CSTART)
        else $error("padding did not start a compression");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!out_valid_reg || m_tready)) |=> m_tvalid && pos_reg == 6'd0)
        else $error("digest not loaded or message state not cleared");

endmodule
